/* rtl/core/qam_pkg.sv */
// Shared types and constants of the quaternion accumulating multiplier.
`default_nettype none

package qam_pkg;

  // Command codes as they arrive on the input channel.
  localparam logic [2:0] CMD_LOAD = 3'd0;
  localparam logic [2:0] CMD_RMUL = 3'd1;
  localparam logic [2:0] CMD_LMUL = 3'd2;
  localparam logic [2:0] CMD_SQR  = 3'd3;
  localparam logic [2:0] CMD_CONJ = 3'd4;
  localparam logic [2:0] CMD_NEG  = 3'd5;

  // Depth of the queue between the decode stage and the execute stage.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Decoded operation, one-hot.
  typedef enum logic [6:0] {
    OP_LOAD = 7'b0000001,
    OP_RMUL = 7'b0000010,
    OP_LMUL = 7'b0000100,
    OP_SQR  = 7'b0001000,
    OP_CONJ = 7'b0010000,
    OP_NEG  = 7'b0100000,
    OP_KEEP = 7'b1000000
  } op_e;

  typedef struct packed {
    logic        [2:0]  cmd;
    logic signed [15:0] in_w;
    logic signed [15:0] in_x;
    logic signed [15:0] in_y;
    logic signed [15:0] in_z;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] out_w;
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic signed [15:0] out_z;
    logic               saturated;
  } out_item_t;

  typedef struct packed {
    logic signed [15:0] w;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } quat16_t;

  // One decoded command as it waits in the queue.
  typedef struct packed {
    op_e     op;
    quat16_t opnd;
  } entry_t;

endpackage

`default_nettype wire

/* rtl/core/qam_front.sv */
// Decode stage: accepts input transfers and turns the command into a one-hot operation.
`default_nettype none

module qam_front
  import qam_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output      logic     in_ready_o,
  input  wire in_item_t in_data_i,
  output      logic     dec_valid_o,
  input  wire logic     dec_ready_i,
  output      entry_t   dec_data_o
);

  logic   valid_q, valid_d;
  entry_t entry_q;
  entry_t entry_d;
  logic   take;

  // Nothing is taken while reset is held.
  assign in_ready_o = rst_ni && (!valid_q || dec_ready_i);
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    entry_d.opnd.w = in_data_i.in_w;
    entry_d.opnd.x = in_data_i.in_x;
    entry_d.opnd.y = in_data_i.in_y;
    entry_d.opnd.z = in_data_i.in_z;
    case (in_data_i.cmd)
      CMD_LOAD: entry_d.op = OP_LOAD;
      CMD_RMUL: entry_d.op = OP_RMUL;
      CMD_LMUL: entry_d.op = OP_LMUL;
      CMD_SQR:  entry_d.op = OP_SQR;
      CMD_CONJ: entry_d.op = OP_CONJ;
      CMD_NEG:  entry_d.op = OP_NEG;
      default:  entry_d.op = OP_KEEP;
    endcase
  end

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (dec_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      entry_q <= entry_d;
    end
  end

  assign dec_valid_o = valid_q;
  assign dec_data_o  = entry_q;

endmodule

`default_nettype wire

/* rtl/core/qam_queue.sv */
// Small register queue between the decode stage and the execute stage.
`default_nettype none

module qam_queue
  import qam_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_valid_i,
  output      logic   push_ready_o,
  input  wire entry_t push_data_i,
  output      logic   pop_valid_o,
  input  wire logic   pop_ready_i,
  output      entry_t pop_data_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  entry_t          mem_q [DEPTH];
  logic [AW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]   count_q, count_d;
  logic            push, pop;

  assign push_ready_o = (count_q != CW'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : AW'(wr_ptr_q + 1'b1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : AW'(rd_ptr_q + 1'b1);
    end
    if (push && !pop) begin
      count_d = CW'(count_q + 1'b1);
    end else if (pop && !push) begin
      count_d = CW'(count_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // The fill count never passes the depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("queue fill count exceeds depth");

  // Pointers can only differ while entries are held.
  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers disagree while empty");

  // The oldest entry does not change while it waits to be taken.
  a_head_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_valid_o && !pop_ready_i) |=> $stable(pop_data_o))
    else $error("queue head changed while waiting");

endmodule

`default_nettype wire

/* rtl/core/qam_back.sv */
// Execute stage: holds the quaternion, registers results, one op per cycle unless stalled.
`default_nettype none

module qam_back
  import qam_pkg::*;
#(
  parameter int unsigned WIDTH     = 16,
  parameter int unsigned FRAC_BITS = 14
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      op_valid_i,
  output      logic      op_ready_o,
  input  wire entry_t    op_data_i,
  output      logic      out_valid_o,
  input  wire logic      out_ready_i,
  output      out_item_t out_data_o
);

  localparam int unsigned MW = (WIDTH > 16) ? WIDTH : 16;
  localparam int unsigned PW = 2 * MW + 2;

  logic signed [WIDTH-1:0] held_q [4];
  logic signed [WIDTH-1:0] held_d [4];
  logic                    flag_d;
  logic                    out_valid_q;
  out_item_t               out_data_q;
  logic                    take;

  logic signed [MW-1:0]    held_ext [4];
  logic signed [MW-1:0]    opnd_ext [4];
  logic signed [MW-1:0]    lhs [4];
  logic signed [MW-1:0]    rhs [4];
  logic signed [2*MW-1:0]  prod [4][4];
  logic signed [PW-1:0]    pe [4][4];
  logic signed [PW-1:0]    ham [4];
  logic [WIDTH:0]          mul_sat [4];
  logic [WIDTH:0]          load_sat [4];
  logic [WIDTH:0]          neg_sat [4];

  // Clip a wide value to WIDTH signed bits; the top bit of the result flags a clip.
  function automatic logic [WIDTH:0] sat_fn(input logic signed [PW-1:0] v);
    logic             fits;
    logic [WIDTH-1:0] r;
    fits = (v[PW-1:WIDTH-1] == {(PW-WIDTH+1){v[WIDTH-1]}});
    if (fits) begin
      r = v[WIDTH-1:0];
    end else if (v[PW-1]) begin
      r = {1'b1, {(WIDTH-1){1'b0}}};
    end else begin
      r = {1'b0, {(WIDTH-1){1'b1}}};
    end
    return {!fits, r};
  endfunction

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign op_ready_o  = !out_valid_q || out_ready_i;
  assign take        = op_valid_i && op_ready_o;

  always_comb begin
    opnd_ext[0] = MW'(op_data_i.opnd.w);
    opnd_ext[1] = MW'(op_data_i.opnd.x);
    opnd_ext[2] = MW'(op_data_i.opnd.y);
    opnd_ext[3] = MW'(op_data_i.opnd.z);
    for (int i = 0; i < 4; i++) begin
      held_ext[i] = MW'(held_q[i]);
      lhs[i]      = (op_data_i.op == OP_LMUL) ? opnd_ext[i] : held_ext[i];
      rhs[i]      = (op_data_i.op == OP_RMUL) ? opnd_ext[i] : held_ext[i];
    end
  end

  // Sixteen independent products of the Hamilton product.
  for (genvar gi = 0; gi < 4; gi++) begin : g_row
    for (genvar gj = 0; gj < 4; gj++) begin : g_col
      assign prod[gi][gj] = lhs[gi] * rhs[gj];
      assign pe[gi][gj]   = PW'(prod[gi][gj]);
    end
  end

  always_comb begin
    ham[0] = pe[0][0] - pe[1][1] - pe[2][2] - pe[3][3];
    ham[1] = pe[0][1] + pe[1][0] + pe[2][3] - pe[3][2];
    ham[2] = pe[0][2] - pe[1][3] + pe[2][0] + pe[3][1];
    ham[3] = pe[0][3] + pe[1][2] - pe[2][1] + pe[3][0];
    for (int i = 0; i < 4; i++) begin
      mul_sat[i]  = sat_fn(ham[i] >>> FRAC_BITS);
      load_sat[i] = sat_fn(PW'(opnd_ext[i]));
      neg_sat[i]  = sat_fn(-PW'(held_q[i]));
    end
  end

  always_comb begin
    flag_d = 1'b0;
    for (int i = 0; i < 4; i++) begin
      held_d[i] = held_q[i];
    end
    case (op_data_i.op)
      OP_LOAD: begin
        for (int i = 0; i < 4; i++) begin
          held_d[i] = load_sat[i][WIDTH-1:0];
          flag_d    = flag_d | load_sat[i][WIDTH];
        end
      end
      OP_RMUL, OP_LMUL, OP_SQR: begin
        for (int i = 0; i < 4; i++) begin
          held_d[i] = mul_sat[i][WIDTH-1:0];
          flag_d    = flag_d | mul_sat[i][WIDTH];
        end
      end
      OP_CONJ: begin
        for (int i = 1; i < 4; i++) begin
          held_d[i] = neg_sat[i][WIDTH-1:0];
          flag_d    = flag_d | neg_sat[i][WIDTH];
        end
      end
      OP_NEG: begin
        for (int i = 0; i < 4; i++) begin
          held_d[i] = neg_sat[i][WIDTH-1:0];
          flag_d    = flag_d | neg_sat[i][WIDTH];
        end
      end
      default: begin
        flag_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        held_q[i] <= '0;
      end
    end else begin
      if (take) begin
        out_valid_q <= 1'b1;
        for (int i = 0; i < 4; i++) begin
          held_q[i] <= held_d[i];
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_data_q.out_w     <= 16'(held_d[0]);
      out_data_q.out_x     <= 16'(held_d[1]);
      out_data_q.out_y     <= 16'(held_d[2]);
      out_data_q.out_z     <= 16'(held_d[3]);
      out_data_q.saturated <= flag_d;
    end
  end

  // A pending result always shows the quaternion now held.
  a_out_matches_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_data_q.out_w == 16'(held_q[0]) &&
                     out_data_q.out_z == 16'(held_q[3])))
    else $error("result register and held quaternion disagree");

  // The state changes only when an operation is executed.
  a_state_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !take |=> ($stable(held_q[0]) && $stable(held_q[1]) &&
               $stable(held_q[2]) && $stable(held_q[3])))
    else $error("held quaternion changed without an operation");

  // An undefined command never reports a clip.
  a_keep_no_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && op_data_i.op == OP_KEEP) |=> !out_data_q.saturated)
    else $error("saturation flagged for an undefined command");

endmodule

`default_nettype wire

/* rtl/core/quaternion_accumulating_multiplier_unit.sv */
// Top level of the quaternion accumulating multiplier: decode stage, queue, execute stage.
`default_nettype none

// Channel   Direction  Handshake                Payload
// in        input      in_valid_i / in_ready_o  in_data_i  (in_item_t: cmd, in_w..in_z)
// out       output     out_valid_o / out_ready_i out_data_o (out_item_t: out_w..out_z, saturated)
//
// One transfer is taken per cycle and one result leaves per cycle while the output does not
// stall; the execute stage computes the new held quaternion combinationally, sixteen
// multipliers feeding four adder trees. A command passes the decode register, a queue entry
// and the result register. At full rate the queue holds one command and keeps one slot spare,
// so the decode stage takes one more transfer after the output stalls; at most four items are
// in flight (decode register, two queue entries, result register). The result register lets
// the execute stage run while the previous result is being taken. Reset clears the held
// quaternion to zero and empties every stage; no item is accepted during reset.

module quaternion_accumulating_multiplier_unit
  import qam_pkg::*;
#(
  parameter int unsigned WIDTH     = 16,
  parameter int unsigned FRAC_BITS = 14
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output      logic      in_ready_o,
  input  wire in_item_t  in_data_i,
  output      logic      out_valid_o,
  input  wire logic      out_ready_i,
  output      out_item_t out_data_o
);

  // Decoded commands leaving the front.
  logic   dec_valid;
  logic   dec_ready;
  entry_t dec_data;

  // Commands leaving the queue toward the execute stage.
  logic   exe_valid;
  logic   exe_ready;
  entry_t exe_data;

  // The front classifies each command into a one-hot operation and registers the operand.
  qam_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .dec_valid_o (dec_valid),
    .dec_ready_i (dec_ready),
    .dec_data_o  (dec_data)
  );

  // The queue decouples the two sides so each can stall on its own.
  qam_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (dec_valid),
    .push_ready_o (dec_ready),
    .push_data_i  (dec_data),
    .pop_valid_o  (exe_valid),
    .pop_ready_i  (exe_ready),
    .pop_data_o   (exe_data)
  );

  // The back holds the quaternion and performs the arithmetic with saturation.
  qam_back #(
    .WIDTH     (WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (exe_valid),
    .op_ready_o  (exe_ready),
    .op_data_i   (exe_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
